/* design/bsr_pkg.sv */
`timescale 1ns / 1ps

package bsr_pkg;

   localparam int PROCS_DEF      = 8;
   localparam int RES_DEF        = 4;
   localparam int COUNT_BITS_DEF = 8;

   localparam int WORK_BASE_W = 12;
   localparam int WORK_MAX    = 4095;

   localparam int CMD_W    = 3;
   localparam int PROC_W   = 3;
   localparam int RESIDX_W = 2;
   localparam int VALUE_W  = 8;
   localparam int STATUS_W = 2;
   localparam int PCFG_W   = 4;
   localparam int RCFG_W   = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 4;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD_ALLOC = 3'd0,
      CMD_LOAD_MAX   = 3'd1,
      CMD_LOAD_AVAIL = 3'd2,
      CMD_CHECK      = 3'd3,
      CMD_REQUEST    = 3'd4
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_SAFE   = 2'd0,
      ST_UNSAFE = 2'd1,
      ST_EXCEED = 2'd2,
      ST_WAIT   = 2'd3
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PROC_COUNT = 2'd0,
      CSR_RES_COUNT  = 2'd1
   } csr_type;

endpackage

/* design/bankers_safety_and_request.sv */
`timescale 1ns / 1ps
// Channel | Direction | Handshake           | Payload
// req_    | in        | req_valid/req_stall | cmd, proc, res, value, last
// rsp_    | out       | rsp_valid/rsp_stall | status, proc_id, seq_valid, last_res
// csr_    | in        | csr_valid/csr_ready | index, data (always ready)
//
// Loads and non-last request elements are taken in the idle state. A check runs a set-up
// state, up to n passes over the n rows (one row read per cycle, all resources
// compared at once), n sequence entries when safe and one final result.
// A request adds a test state, and one more state to roll back an unsafe grant.
// Synchronous reset clears the control state and counts to 8 and 4.
// A stalled result holds in the output register; req_stall stays high
// until the final transaction of the current item has been loaded.

module bankers_safety_and_request #(
   parameter int PROCS      = bsr_pkg::PROCS_DEF,
   parameter int RES        = bsr_pkg::RES_DEF,
   parameter int COUNT_BITS = bsr_pkg::COUNT_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [bsr_pkg::CMD_W-1:0]       req_cmd,
   input  logic [bsr_pkg::PROC_W-1:0]      req_proc,
   input  logic [bsr_pkg::RESIDX_W-1:0]    req_res,
   input  logic [bsr_pkg::VALUE_W-1:0]     req_value,
   input  logic                            req_last,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [bsr_pkg::STATUS_W-1:0]    rsp_status,
   output logic [bsr_pkg::PROC_W-1:0]      rsp_proc_id,
   output logic                            rsp_seq_valid,
   output logic                            rsp_last_res,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [bsr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bsr_pkg::CSR_DATA_W-1:0]  csr_data
);

   localparam int CB     = COUNT_BITS;
   localparam int PIW    = (PROCS > 1) ? $clog2(PROCS) : 1;
   localparam int PCW    = $clog2(PROCS + 1);
   localparam int RCW    = $clog2(RES + 1);
   localparam int WORK_W = (CB > bsr_pkg::WORK_BASE_W) ? CB : bsr_pkg::WORK_BASE_W;
   localparam int SUM_W  = WORK_W + 1;
   localparam int CMP_W  = SUM_W + 1;
   localparam int ROW_W  = RES * CB;

   typedef enum logic [2:0] {
      S_IDLE, S_REQ_CHK, S_INIT, S_SCAN, S_ROLL, S_SEQ, S_FIN
   } state_type;

   state_type                     state_ff;
   logic [bsr_pkg::PCFG_W-1:0]    pcfg_ff;
   logic [bsr_pkg::RCFG_W-1:0]    rcfg_ff;
   logic [CB-1:0]                 avail_ff  [RES];
   logic [CB-1:0]                 reqbuf_ff [RES];
   logic [WORK_W-1:0]             work_ff   [RES];
   logic [PROCS-1:0]              fin_ff;
   logic [PIW-1:0]                order_ff  [PROCS];
   logic [PCW-1:0]                cnt_ff;
   logic                          found_ff;
   logic [PIW-1:0]                rd_idx_ff;
   logic [PIW-1:0]                ev_idx_ff;
   logic [PIW-1:0]                k_ff;
   logic [PIW-1:0]                proc_ff;
   logic                          from_req_ff;
   bsr_pkg::status_type           status_ff;
   logic [ROW_W-1:0]              alloc_sv_ff;
   logic                          rsp_valid_ff;
   logic [bsr_pkg::STATUS_W-1:0]  rsp_status_ff;
   logic [bsr_pkg::PROC_W-1:0]    rsp_proc_id_ff;
   logic                          rsp_seq_valid_ff;
   logic                          rsp_last_res_ff;

   logic [PCW-1:0]                n_cnt;
   logic [RCW-1:0]                m_cnt;
   logic [PIW-1:0]                n_last;
   logic [RES-1:0]                lane_use;
   logic                          in_acc;
   logic                          out_free;
   logic                          rsp_load;
   logic                          load_p_ok;
   logic                          res_ok;

   logic                          aw_en;
   logic [RES-1:0]                aw_lane;
   logic [PIW-1:0]                aw_addr;
   logic [ROW_W-1:0]              aw_data;
   logic                          cw_en;
   logic [PIW-1:0]                rd_addr;
   logic [ROW_W-1:0]              alloc_row;
   logic [ROW_W-1:0]              claim_row;
   logic [ROW_W-1:0]              grant_row;
   logic [ROW_W-1:0]              load_row;
   logic [RES-1:0]                load_lane;

   logic signed [CMP_W-1:0]       need_w [RES];
   logic [WORK_W-1:0]             work_add [RES];
   logic [SUM_W-1:0]              sum_w [RES];
   logic                          fits;
   logic                          exceed;
   logic                          short_av;
   logic [PIW-1:0]                rd_next;

   assign n_cnt = (pcfg_ff == '0) ? PCW'(1) :
                  ((32'(pcfg_ff) > PROCS) ? PCW'(PROCS) : PCW'(pcfg_ff));
   assign m_cnt = (rcfg_ff == '0) ? RCW'(1) :
                  ((32'(rcfg_ff) > RES) ? RCW'(RES) : RCW'(rcfg_ff));
   assign n_last = PIW'(n_cnt - PCW'(1));

   always_comb begin
      for (int j = 0; j < RES; j++) begin
         lane_use[j] = (j < 32'(m_cnt));
      end
   end

   assign in_acc    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_load  = out_free && (state_ff == S_SEQ || state_ff == S_FIN);
   assign load_p_ok = 32'(req_proc) < PROCS;
   assign res_ok    = 32'(req_res) < RES;
   assign load_lane = RES'(1) << req_res;
   assign rd_next   = (rd_idx_ff == n_last) ? '0 : PIW'(rd_idx_ff + PIW'(1));

   always_comb begin
      for (int j = 0; j < RES; j++) begin
         load_row[j*CB +: CB]  = CB'(req_value);
         grant_row[j*CB +: CB] = alloc_row[j*CB +: CB] + reqbuf_ff[j];
      end
   end

   always_comb begin
      fits     = 1'b1;
      exceed   = 1'b0;
      short_av = 1'b0;
      for (int j = 0; j < RES; j++) begin
         need_w[j]   = signed'(CMP_W'(claim_row[j*CB +: CB]))
                     - signed'(CMP_W'(alloc_row[j*CB +: CB]));
         sum_w[j]    = SUM_W'(work_ff[j]) + SUM_W'(alloc_row[j*CB +: CB]);
         work_add[j] = (sum_w[j] > SUM_W'(bsr_pkg::WORK_MAX)) ?
                       WORK_W'(bsr_pkg::WORK_MAX) : sum_w[j][WORK_W-1:0];
         if (lane_use[j]) begin
            if (need_w[j] > signed'(CMP_W'(work_ff[j]))) fits = 1'b0;
            if (signed'(CMP_W'(reqbuf_ff[j])) > need_w[j]) exceed = 1'b1;
            if (reqbuf_ff[j] > avail_ff[j]) short_av = 1'b1;
         end
      end
   end

   always_comb begin
      aw_en   = 1'b0;
      aw_lane = load_lane;
      aw_addr = PIW'(req_proc);
      aw_data = load_row;
      cw_en   = 1'b0;
      rd_addr = '0;
      case (state_ff)
         S_IDLE: begin
            rd_addr = PIW'(req_proc);
            aw_en   = in_acc && req_cmd == bsr_pkg::CMD_LOAD_ALLOC && load_p_ok && res_ok;
            cw_en   = in_acc && req_cmd == bsr_pkg::CMD_LOAD_MAX && load_p_ok && res_ok;
         end
         S_REQ_CHK: begin
            aw_en   = !exceed && !short_av;
            aw_lane = lane_use;
            aw_addr = proc_ff;
            aw_data = grant_row;
         end
         S_SCAN: begin
            rd_addr = rd_idx_ff;
         end
         S_ROLL: begin
            aw_en   = 1'b1;
            aw_lane = '1;
            aw_addr = proc_ff;
            aw_data = alloc_sv_ff;
         end
         default: begin
            rd_addr = '0;
         end
      endcase
   end

   bsr_row_mem #(
      .ROWS(PROCS), .LANES(RES), .LANE_W(CB), .ADDR_W(PIW)
   ) u_alloc_mem (
      .clock(clock), .wr_en(aw_en), .wr_lane(aw_lane), .wr_addr(aw_addr),
      .wr_data(aw_data), .rd_addr(rd_addr), .rd_data(alloc_row)
   );

   bsr_row_mem #(
      .ROWS(PROCS), .LANES(RES), .LANE_W(CB), .ADDR_W(PIW)
   ) u_claim_mem (
      .clock(clock), .wr_en(cw_en), .wr_lane(load_lane), .wr_addr(PIW'(req_proc)),
      .wr_data(load_row), .rd_addr(rd_addr), .rd_data(claim_row)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         pcfg_ff      <= bsr_pkg::PCFG_W'(8);
         rcfg_ff      <= bsr_pkg::RCFG_W'(4);
         fin_ff       <= '0;
         cnt_ff       <= '0;
         found_ff     <= 1'b0;
         from_req_ff  <= 1'b0;
         for (int j = 0; j < RES; j++) work_ff[j] <= '0;
         for (int i = 0; i < PROCS; i++) order_ff[i] <= '0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && !rsp_load) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (in_acc) begin
                  case (req_cmd)
                     bsr_pkg::CMD_LOAD_AVAIL: begin
                        if (res_ok) avail_ff[req_res] <= CB'(req_value);
                     end
                     bsr_pkg::CMD_CHECK: begin
                        from_req_ff <= 1'b0;
                        state_ff    <= S_INIT;
                     end
                     bsr_pkg::CMD_REQUEST: begin
                        if (res_ok) reqbuf_ff[req_res] <= CB'(req_value);
                        if (req_last) begin
                           if (32'(req_proc) >= 32'(n_cnt)) begin
                              status_ff <= bsr_pkg::ST_EXCEED;
                              state_ff  <= S_FIN;
                           end else begin
                              proc_ff  <= PIW'(req_proc);
                              state_ff <= S_REQ_CHK;
                           end
                        end
                     end
                     default: begin
                        state_ff <= S_IDLE;
                     end
                  endcase
               end
            end
            S_REQ_CHK: begin
               if (exceed) begin
                  status_ff <= bsr_pkg::ST_EXCEED;
                  state_ff  <= S_FIN;
               end else if (short_av) begin
                  status_ff <= bsr_pkg::ST_WAIT;
                  state_ff  <= S_FIN;
               end else begin
                  for (int j = 0; j < RES; j++) begin
                     if (lane_use[j]) avail_ff[j] <= avail_ff[j] - reqbuf_ff[j];
                  end
                  alloc_sv_ff <= alloc_row;
                  from_req_ff <= 1'b1;
                  state_ff    <= S_INIT;
               end
            end
            S_INIT: begin
               for (int j = 0; j < RES; j++) begin
                  work_ff[j] <= lane_use[j] ? WORK_W'(avail_ff[j]) : '0;
               end
               fin_ff    <= '0;
               cnt_ff    <= '0;
               found_ff  <= 1'b0;
               ev_idx_ff <= '0;
               rd_idx_ff <= (n_last == '0) ? '0 : PIW'(1);
               state_ff  <= S_SCAN;
            end
            S_SCAN: begin
               logic take;
               logic [PCW-1:0] cnt_nx;
               take   = !fin_ff[ev_idx_ff] && fits;
               cnt_nx = cnt_ff + PCW'(take);
               if (take) begin
                  for (int j = 0; j < RES; j++) begin
                     if (lane_use[j]) work_ff[j] <= work_add[j];
                  end
                  fin_ff[ev_idx_ff]         <= 1'b1;
                  order_ff[PIW'(cnt_ff)]    <= ev_idx_ff;
               end
               cnt_ff    <= cnt_nx;
               found_ff  <= (ev_idx_ff == n_last) ? 1'b0 : (found_ff || take);
               ev_idx_ff <= rd_idx_ff;
               rd_idx_ff <= rd_next;
               if (ev_idx_ff == n_last) begin
                  if (cnt_nx == n_cnt) begin
                     status_ff <= bsr_pkg::ST_SAFE;
                     k_ff      <= '0;
                     state_ff  <= S_SEQ;
                  end else if (!(found_ff || take)) begin
                     status_ff <= bsr_pkg::ST_UNSAFE;
                     state_ff  <= from_req_ff ? S_ROLL : S_FIN;
                  end
               end
            end
            S_ROLL: begin
               for (int j = 0; j < RES; j++) begin
                  if (lane_use[j]) avail_ff[j] <= avail_ff[j] + reqbuf_ff[j];
               end
               state_ff <= S_FIN;
            end
            S_SEQ: begin
               if (out_free) begin
                  rsp_valid_ff     <= 1'b1;
                  rsp_status_ff    <= bsr_pkg::ST_SAFE;
                  rsp_proc_id_ff   <= bsr_pkg::PROC_W'(order_ff[k_ff]);
                  rsp_seq_valid_ff <= 1'b1;
                  rsp_last_res_ff  <= 1'b0;
                  k_ff             <= PIW'(k_ff + PIW'(1));
                  if (k_ff == n_last) state_ff <= S_FIN;
               end
            end
            S_FIN: begin
               if (out_free) begin
                  rsp_valid_ff     <= 1'b1;
                  rsp_status_ff    <= status_ff;
                  rsp_proc_id_ff   <= '0;
                  rsp_seq_valid_ff <= 1'b0;
                  rsp_last_res_ff  <= 1'b1;
                  state_ff         <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase

         if (csr_valid && csr_ready) begin
            case (csr_index)
               bsr_pkg::CSR_PROC_COUNT: pcfg_ff <= csr_data[bsr_pkg::PCFG_W-1:0];
               bsr_pkg::CSR_RES_COUNT:  rcfg_ff <= csr_data[bsr_pkg::RCFG_W-1:0];
               default: begin
                  pcfg_ff <= pcfg_ff;
               end
            endcase
         end
      end
   end

   assign req_stall     = (state_ff != S_IDLE);
   assign csr_ready     = 1'b1;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_proc_id   = rsp_proc_id_ff;
   assign rsp_seq_valid = rsp_seq_valid_ff;
   assign rsp_last_res  = rsp_last_res_ff;

endmodule

/* design/bsr_row_mem.sv */
`timescale 1ns / 1ps

module bsr_row_mem #(
   parameter int ROWS   = 8,
   parameter int LANES  = 4,
   parameter int LANE_W = 8,
   parameter int ADDR_W = 3
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [LANES-1:0]          wr_lane,
   input  logic [ADDR_W-1:0]         wr_addr,
   input  logic [LANES*LANE_W-1:0]   wr_data,
   input  logic [ADDR_W-1:0]         rd_addr,
   output logic [LANES*LANE_W-1:0]   rd_data
);

   logic [LANES*LANE_W-1:0] mem [ROWS];

   always_ff @(posedge clock) begin
      for (int l = 0; l < LANES; l++) begin
         if (wr_en && wr_lane[l]) begin
            mem[wr_addr][l*LANE_W +: LANE_W] <= wr_data[l*LANE_W +: LANE_W];
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

/* design/bsr_checker.sv */
`timescale 1ns / 1ps

module bsr_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input logic [bsr_pkg::CMD_W-1:0]       req_cmd,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic [bsr_pkg::STATUS_W-1:0]    rsp_status,
   input logic [bsr_pkg::PROC_W-1:0]      rsp_proc_id,
   input logic                            rsp_seq_valid,
   input logic                            rsp_last_res
);

   // stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_proc_id) && $stable(rsp_seq_valid) && $stable(rsp_last_res))
      else $error("stalled result changed");

   a_seq_entry: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_res |-> rsp_seq_valid && rsp_status == bsr_pkg::ST_SAFE)
      else $error("sequence entry malformed");

   a_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_res |-> !rsp_seq_valid && rsp_proc_id == '0)
      else $error("final result malformed");

   a_check_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_cmd == bsr_pkg::CMD_CHECK |=> req_stall)
      else $error("check accepted without going busy");

endmodule

bind bankers_safety_and_request bsr_checker u_bsr_checker (.*);

/* tb/bsr_checker.sv */
`timescale 1ns / 1ps

module bsr_tb_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  logic [bsr_pkg::CMD_W-1:0]      req_cmd,
   input  logic [bsr_pkg::PROC_W-1:0]     req_proc,
   input  logic [bsr_pkg::RESIDX_W-1:0]   req_res,
   input  logic [bsr_pkg::VALUE_W-1:0]    req_value,
   input  logic                           req_last,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  logic [bsr_pkg::STATUS_W-1:0]   rsp_status,
   input  logic [bsr_pkg::PROC_W-1:0]     rsp_proc_id,
   input  logic                           rsp_seq_valid,
   input  logic                           rsp_last_res,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [bsr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bsr_pkg::CSR_DATA_W-1:0] csr_data,
   output int                             fail_count,
   output int                             pending
);

   typedef struct packed {
      logic [bsr_pkg::STATUS_W-1:0] status;
      logic [bsr_pkg::PROC_W-1:0]   proc_id;
      logic                         seq_valid;
      logic                         last_res;
   } bank_result_type;

   logic [bsr_pkg::VALUE_W-1:0] alloc_cnt [bsr_pkg::PROCS_DEF][bsr_pkg::RES_DEF];
   logic [bsr_pkg::VALUE_W-1:0] claim_cnt [bsr_pkg::PROCS_DEF][bsr_pkg::RES_DEF];
   logic [bsr_pkg::VALUE_W-1:0] avail_cnt [bsr_pkg::RES_DEF];
   logic [bsr_pkg::VALUE_W-1:0] req_buf   [bsr_pkg::RES_DEF];
   logic [bsr_pkg::PCFG_W-1:0]  proc_cfg;
   logic [bsr_pkg::RCFG_W-1:0]  res_cfg;
   logic [bsr_pkg::PROC_W-1:0]  safe_seq  [bsr_pkg::PROCS_DEF];
   bank_result_type             due_results [$];

   assign pending = due_results.size();

   function automatic int procs_used();
      if (proc_cfg == 0) return 1;
      if (proc_cfg > bsr_pkg::PROCS_DEF) return bsr_pkg::PROCS_DEF;
      return int'(proc_cfg);
   endfunction

   function automatic int res_used();
      if (res_cfg == 0) return 1;
      if (res_cfg > bsr_pkg::RES_DEF) return bsr_pkg::RES_DEF;
      return int'(res_cfg);
   endfunction

   function automatic int need_of(int p, int r);
      return int'(claim_cnt[p][r]) - int'(alloc_cnt[p][r]);
   endfunction

   function automatic bit find_safe_order();
      int  n, m, cnt;
      int  work [bsr_pkg::RES_DEF];
      bit  done [bsr_pkg::PROCS_DEF];
      bit  progress, fits;
      n = procs_used();
      m = res_used();
      cnt = 0;
      for (int j = 0; j < bsr_pkg::RES_DEF; j++)
         work[j] = (j < m) ? int'(avail_cnt[j]) : 0;
      for (int i = 0; i < bsr_pkg::PROCS_DEF; i++) done[i] = 0;
      while (cnt < n) begin
         progress = 0;
         for (int i = 0; i < n; i++) begin
            if (!done[i]) begin
               fits = 1;
               for (int j = 0; j < m; j++)
                  if (need_of(i, j) > work[j]) fits = 0;
               if (fits) begin
                  for (int j = 0; j < m; j++) begin
                     work[j] = work[j] + int'(alloc_cnt[i][j]);
                     if (work[j] > bsr_pkg::WORK_MAX) work[j] = bsr_pkg::WORK_MAX;
                  end
                  safe_seq[cnt] = bsr_pkg::PROC_W'(i);
                  cnt++;
                  done[i] = 1;
                  progress = 1;
               end
            end
         end
         if (!progress) break;
      end
      return cnt == n;
   endfunction

   function automatic void push_final(bsr_pkg::status_type st);
      bank_result_type r;
      r.status = st;
      r.proc_id = '0;
      r.seq_valid = 0;
      r.last_res = 1;
      due_results.push_back(r);
   endfunction

   function automatic bit predict_check();
      bank_result_type r;
      if (!find_safe_order()) begin
         push_final(bsr_pkg::ST_UNSAFE);
         return 0;
      end
      for (int i = 0; i < procs_used(); i++) begin
         r.status = bsr_pkg::ST_SAFE;
         r.proc_id = safe_seq[i];
         r.seq_valid = 1;
         r.last_res = 0;
         due_results.push_back(r);
      end
      push_final(bsr_pkg::ST_SAFE);
      return 1;
   endfunction

   task automatic predict_request(int p);
      int m;
      m = res_used();
      if (p >= procs_used()) begin
         push_final(bsr_pkg::ST_EXCEED);
         return;
      end
      for (int j = 0; j < m; j++)
         if (int'(req_buf[j]) > need_of(p, j)) begin
            push_final(bsr_pkg::ST_EXCEED);
            return;
         end
      for (int j = 0; j < m; j++)
         if (req_buf[j] > avail_cnt[j]) begin
            push_final(bsr_pkg::ST_WAIT);
            return;
         end
      for (int j = 0; j < m; j++) begin
         avail_cnt[j] -= req_buf[j];
         alloc_cnt[p][j] += req_buf[j];
      end
      if (!predict_check())
         for (int j = 0; j < m; j++) begin
            avail_cnt[j] += req_buf[j];
            alloc_cnt[p][j] -= req_buf[j];
         end
   endtask

   task automatic report(string what, int got, int want);
      $display("%0t mismatch: %s got %0d expected %0d", $time, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      bank_result_type want;
      if (reset) begin
         due_results.delete();
         fail_count = 0;
         proc_cfg <= bsr_pkg::PCFG_W'(bsr_pkg::PROCS_DEF);
         res_cfg <= bsr_pkg::RCFG_W'(bsr_pkg::RES_DEF);
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               bsr_pkg::CSR_PROC_COUNT: proc_cfg <= csr_data;
               bsr_pkg::CSR_RES_COUNT:  res_cfg <= csr_data[bsr_pkg::RCFG_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            case (req_cmd)
               bsr_pkg::CMD_LOAD_ALLOC: alloc_cnt[req_proc][req_res] = req_value;
               bsr_pkg::CMD_LOAD_MAX:   claim_cnt[req_proc][req_res] = req_value;
               bsr_pkg::CMD_LOAD_AVAIL: avail_cnt[req_res] = req_value;
               bsr_pkg::CMD_CHECK:      void'(predict_check());
               bsr_pkg::CMD_REQUEST: begin
                  req_buf[req_res] = req_value;
                  if (req_last) predict_request(int'(req_proc));
               end
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (due_results.size() == 0) begin
               report("unexpected results", 1, 0);
            end else begin
               want = due_results.pop_front();
               if (rsp_status != want.status) report("status", rsp_status, want.status);
               if (rsp_proc_id != want.proc_id) report("proc_id", rsp_proc_id, want.proc_id);
               if (rsp_seq_valid != want.seq_valid)
                  report("seq_valid", rsp_seq_valid, want.seq_valid);
               if (rsp_last_res != want.last_res)
                  report("last_res", rsp_last_res, want.last_res);
            end
         end
      end
   end

endmodule

/* tb/bankers_safety_and_request_tb.sv */
`timescale 1ns / 1ps

module bankers_safety_and_request_tb;

   localparam int QUIET_LIMIT = 20000;
   localparam int SETTLE      = 120;

   logic                           clock = 0;
   logic                           reset = 1;
   logic                           req_valid = 0;
   logic                           req_stall;
   logic [bsr_pkg::CMD_W-1:0]      req_cmd = '0;
   logic [bsr_pkg::PROC_W-1:0]     req_proc = '0;
   logic [bsr_pkg::RESIDX_W-1:0]   req_res = '0;
   logic [bsr_pkg::VALUE_W-1:0]    req_value = '0;
   logic                           req_last = 0;
   logic                           rsp_valid;
   logic                           rsp_stall = 0;
   logic [bsr_pkg::STATUS_W-1:0]   rsp_status;
   logic [bsr_pkg::PROC_W-1:0]     rsp_proc_id;
   logic                           rsp_seq_valid;
   logic                           rsp_last_res;
   logic                           csr_valid = 0;
   logic                           csr_ready;
   logic [bsr_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [bsr_pkg::CSR_DATA_W-1:0] csr_data = '0;

   int fail_count, pending, quiet;
   bit long_hold = 0;
   bit no_gaps = 0;
   int res_now = bsr_pkg::RES_DEF;

   always #5 clock = ~clock;

   bankers_safety_and_request u_top (.*);

   bsr_tb_checker u_chk (.*);

   // receiver: random stalls, with one long hold-off on demand
   initial begin
      int hold;
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_stall <= 1;
            for (hold = 0; hold < 400; hold++) @(posedge clock);
            long_hold = 0;
            rsp_stall <= 0;
         end else if (no_gaps) rsp_stall <= 0;
         else if ($urandom_range(0, 99) < 75) rsp_stall <= 0;
         else if ($urandom_range(0, 19) == 0) begin
            rsp_stall <= 1;
            repeat ($urandom_range(10, 40)) @(posedge clock);
         end else rsp_stall <= 1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         quiet <= 0;
      else if (quiet >= QUIET_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else quiet <= quiet + 1;
   end

   task automatic send(bsr_pkg::cmd_type c, int p, int r, int v, bit l);
      int gap;
      gap = 0;
      if (!no_gaps) begin
         gap = $urandom_range(0, 99);
         gap = (gap < 65) ? 0 : (gap < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      end
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_cmd <= c;
      req_proc <= bsr_pkg::PROC_W'(p);
      req_res <= bsr_pkg::RESIDX_W'(r);
      req_value <= bsr_pkg::VALUE_W'(v);
      req_last <= l;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(bsr_pkg::csr_type idx, int d);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= bsr_pkg::CSR_DATA_W'(d);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
   endtask

   task automatic configure(int pc, int rc);
      drain();
      csr_write(bsr_pkg::CSR_PROC_COUNT, pc);
      csr_write(bsr_pkg::CSR_RES_COUNT, rc);
      res_now = (rc % 8 == 0) ? 1 : (rc % 8 > bsr_pkg::RES_DEF) ? bsr_pkg::RES_DEF : rc % 8;
   endtask

   task automatic request_seq(int p, int maxv, bit broken);
      int n;
      n = broken ? $urandom_range(1, bsr_pkg::RES_DEF) : res_now;
      for (int j = 0; j < n; j++)
         send(bsr_pkg::CMD_REQUEST, p, j, $urandom_range(0, maxv), j == n - 1);
   endtask

   task automatic random_item();
      int k, p, r;
      k = $urandom_range(0, 99);
      p = $urandom_range(0, 7);
      r = $urandom_range(0, 3);
      if (k < 35) request_seq(p, ($urandom_range(0, 9) == 0) ? 255 : 3,
                              $urandom_range(0, 9) == 0);
      else if (k < 50) send(bsr_pkg::CMD_CHECK, p, r, $urandom_range(0, 255),
                            1'($urandom_range(0, 1)));
      else if (k < 65) send(bsr_pkg::CMD_LOAD_ALLOC, p, r, $urandom_range(0, 4),
                            1'($urandom_range(0, 1)));
      else if (k < 80) send(bsr_pkg::CMD_LOAD_MAX, p, r, $urandom_range(0, 9),
                            1'($urandom_range(0, 1)));
      else if (k < 92) send(bsr_pkg::CMD_LOAD_AVAIL, p, r, $urandom_range(0, 8),
                            1'($urandom_range(0, 1)));
      else if (k < 96) send(bsr_pkg::cmd_type'(bsr_pkg::CMD_W'($urandom_range(5, 7))), p, r,
                            $urandom_range(0, 255), 1'b1);
      else send(bsr_pkg::cmd_type'(bsr_pkg::CMD_W'($urandom_range(0, 2))), p, r,
                $urandom_range(128, 255), 1'b0);
   endtask

   initial begin
      int pcs [8] = '{8, 1, 0, 15, 3, 5, 8, 2};
      int rcs [8] = '{4, 1, 0, 7, 2, 3, 12, 4};
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // every table entry and the request buffer written before any read
      for (int p = 0; p < bsr_pkg::PROCS_DEF; p++)
         for (int r = 0; r < bsr_pkg::RES_DEF; r++) begin
            send(bsr_pkg::CMD_LOAD_ALLOC, p, r, $urandom_range(0, 3), 1'b0);
            send(bsr_pkg::CMD_LOAD_MAX, p, r, $urandom_range(3, 7), 1'b1);
         end
      for (int r = 0; r < bsr_pkg::RES_DEF; r++)
         send(bsr_pkg::CMD_LOAD_AVAIL, 0, r, $urandom_range(2, 6), 1'b0);
      request_seq(0, 0, 1'b0);

      // directed
      send(bsr_pkg::CMD_CHECK, 0, 0, 0, 1'b0);
      send(bsr_pkg::CMD_REQUEST, 1, 3, 255, 1'b1);
      send(bsr_pkg::CMD_LOAD_MAX, 2, 0, 255, 1'b0);
      send(bsr_pkg::CMD_LOAD_ALLOC, 2, 0, 0, 1'b0);
      for (int j = 0; j < bsr_pkg::RES_DEF; j++)
         send(bsr_pkg::CMD_REQUEST, 2, j, (j == 0) ? 200 : 0, j == 3);
      send(bsr_pkg::CMD_LOAD_ALLOC, 3, 1, 255, 1'b1);
      send(bsr_pkg::CMD_CHECK, 7, 3, 255, 1'b1);
      send(bsr_pkg::CMD_REQUEST, 3, 3, 0, 1'b1);
      send(bsr_pkg::cmd_type'(3'd5), 7, 3, 255, 1'b1);
      send(bsr_pkg::cmd_type'(3'd6), 0, 0, 0, 1'b0);
      send(bsr_pkg::cmd_type'(3'd7), 5, 2, 170, 1'b1);
      send(bsr_pkg::CMD_LOAD_ALLOC, 3, 1, 1, 1'b0);
      for (int r = 0; r < bsr_pkg::RES_DEF; r++)
         send(bsr_pkg::CMD_LOAD_AVAIL, 0, r, 255, 1'b0);
      send(bsr_pkg::CMD_CHECK, 0, 0, 0, 1'b0);
      for (int r = 0; r < bsr_pkg::RES_DEF; r++)
         send(bsr_pkg::CMD_LOAD_AVAIL, 7, r, 0, 1'b1);
      send(bsr_pkg::CMD_CHECK, 0, 0, 0, 1'b0);
      configure(3, 2);
      send(bsr_pkg::CMD_REQUEST, 7, 0, 0, 1'b1);
      send(bsr_pkg::CMD_REQUEST, 2, 0, 1, 1'b1);

      for (int ph = 0; ph < 8; ph++) begin
         configure(pcs[ph], rcs[ph]);
         if (ph == 2) long_hold = 1;
         no_gaps = (ph == 2 || ph == 5);
         for (int i = 0; i < 25; i++) random_item();
         if (ph == 4) drain();
      end
      no_gaps = 0;

      drain();
      if (fail_count == 0 && pending == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

endmodule
